>>> rtl/core/utcep_pkg.sv
`timescale 1ns / 1ps

package utcep_pkg;

  // Timestamp form: YYYY-MM-DDTHH:MM:SSZ
  localparam int unsigned TS_LEN  = 20;
  localparam int unsigned POS_SAT = 21;
  localparam int unsigned POS_W   = 5;

  localparam logic [POS_W-1:0] POS_DASH_YEAR  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_DASH_MONTH = POS_W'(7);
  localparam logic [POS_W-1:0] POS_TEE        = POS_W'(10);
  localparam logic [POS_W-1:0] POS_COLON_HOUR = POS_W'(13);
  localparam logic [POS_W-1:0] POS_COLON_MIN  = POS_W'(16);
  localparam logic [POS_W-1:0] POS_ZULU       = POS_W'(19);
  localparam logic [POS_W-1:0] POS_LEN        = POS_W'(TS_LEN);
  localparam logic [POS_W-1:0] POS_MAX        = POS_W'(POS_SAT);

  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_TEE   = 8'h54;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZULU  = 8'h5A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned FIELD_W = 7;
  localparam int unsigned EPOCH_W = 39;

  localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
  localparam logic [FIELD_W-1:0] HOUR_MAX   = FIELD_W'(23);
  localparam logic [FIELD_W-1:0] MINSEC_MAX = FIELD_W'(59);
  localparam logic [FIELD_W-1:0] MONTH_FEB  = FIELD_W'(2);
  localparam logic [FIELD_W-1:0] MONTH_DEC  = FIELD_W'(12);

  // Reciprocal of 25 scaled by 2^15; exact floor for numerators below 2600.
  localparam int unsigned RECIP25   = 1311;
  localparam int unsigned RECIP_SH  = 15;
  localparam int unsigned ERA_OFS   = 400;
  localparam int unsigned DAYS_ERA  = 146097;
  // 719468 days from 0000-03-01 to the epoch, plus the one-era offset.
  localparam int unsigned EPOCH_OFS = 865565;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic               form_ok;
  } job_t;

  // Queue status seen by the two sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Days from March 1 to the first day of the month (March-based year).
  function automatic logic [8:0] month_offset(input logic [FIELD_W-1:0] m);
    logic [8:0] r;
    unique case (m)
      FIELD_W'(1):  r = 9'd306;
      FIELD_W'(2):  r = 9'd337;
      FIELD_W'(3):  r = 9'd0;
      FIELD_W'(4):  r = 9'd31;
      FIELD_W'(5):  r = 9'd61;
      FIELD_W'(6):  r = 9'd92;
      FIELD_W'(7):  r = 9'd122;
      FIELD_W'(8):  r = 9'd153;
      FIELD_W'(9):  r = 9'd184;
      FIELD_W'(10): r = 9'd214;
      FIELD_W'(11): r = 9'd245;
      FIELD_W'(12): r = 9'd275;
      default:      r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [FIELD_W-1:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      FIELD_W'(2):  r = leap ? 5'd29 : 5'd28;
      FIELD_W'(4),
      FIELD_W'(6),
      FIELD_W'(9),
      FIELD_W'(11): r = 5'd30;
      default:      r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/utcep_ifs.sv
`timescale 1ns / 1ps

interface utcep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source(output valid, output char_code, output is_last, input ready);
  modport sink(input valid, input char_code, input is_last, output ready);
endinterface

interface utcep_out_if;
  logic                                valid;
  logic                                ready;
  logic                                valid_res;
  logic signed [utcep_pkg::EPOCH_W-1:0] epoch_seconds;

  modport source(output valid, output valid_res, output epoch_seconds, input ready);
  modport sink(input valid, input valid_res, input epoch_seconds, output ready);
endinterface

>>> rtl/core/utc_timestamp_to_epoch_parser_unit.sv
`timescale 1ns / 1ps

// Channel  | Dir | Payload                                  | Transfer
// in_ch    | in  | char_code[7:0], is_last                  | valid && ready
// out_ch   | out | valid_res, epoch_seconds[38:0] (signed)  | valid && ready
//
// The parser takes one character per cycle; ready drops only while the
// two-entry request queue holds two finished timestamps.
// Each timestamp request goes through the conversion sequencer (pop, five
// arithmetic steps, output load) before the next is popped, which sets the sustained rate.
// A result waits in the output register while the parser keeps accepting.
// Reset is synchronous and active low; it clears the parser, queue and sequencer.
module utc_timestamp_to_epoch_parser_unit (
  input  logic         clk,
  input  logic         rst_n,
  utcep_in_if.sink     in_ch,
  utcep_out_if.source  out_ch
);

  utcep_pkg::q_status_t q_status;
  utcep_pkg::job_t      push_job;
  utcep_pkg::job_t      pop_job;
  logic                 push;
  logic                 pop;

  utcep_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  utcep_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_status (q_status)
  );

  utcep_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .pop_job  (pop_job),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

>>> rtl/core/utcep_front.sv
`timescale 1ns / 1ps

module utcep_front (
  input  logic                 clk,
  input  logic                 rst_n,
  utcep_in_if.sink             in_ch,
  input  utcep_pkg::q_status_t q_status,
  output logic                 push,
  output utcep_pkg::job_t      push_job
);

  logic [utcep_pkg::POS_W-1:0]   pos_r, pos_nxt, pos_upd;
  logic                          err_r, err_nxt, err_upd;
  logic [utcep_pkg::YEAR_W-1:0]  year_r, year_nxt, year_upd;
  logic [utcep_pkg::FIELD_W-1:0] month_r, month_nxt, month_upd;
  logic [utcep_pkg::FIELD_W-1:0] day_r, day_nxt, day_upd;
  logic [utcep_pkg::FIELD_W-1:0] hour_r, hour_nxt, hour_upd;
  logic [utcep_pkg::FIELD_W-1:0] min_r, min_nxt, min_upd;
  logic [utcep_pkg::FIELD_W-1:0] sec_r, sec_nxt, sec_upd;
  logic                          accept;
  logic                          is_digit;
  logic [3:0]                    dv;
  logic [7:0]                    c;
  logic [utcep_pkg::POS_W-1:0]   p;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.char_code;
  assign p           = pos_r;
  assign is_digit    = (c >= utcep_pkg::CHAR_ZERO) && (c <= utcep_pkg::CHAR_NINE);
  assign dv          = is_digit ? 4'(c - utcep_pkg::CHAR_ZERO) : 4'd0;

  always_comb begin
    err_upd   = err_r;
    year_upd  = year_r;
    month_upd = month_r;
    day_upd   = day_r;
    hour_upd  = hour_r;
    min_upd   = min_r;
    sec_upd   = sec_r;
    priority if (p >= utcep_pkg::POS_LEN) begin
      err_upd = 1'b1;
    end else if (p == utcep_pkg::POS_DASH_YEAR || p == utcep_pkg::POS_DASH_MONTH) begin
      if (c != utcep_pkg::CHAR_DASH) err_upd = 1'b1;
    end else if (p == utcep_pkg::POS_TEE) begin
      if (c != utcep_pkg::CHAR_TEE) err_upd = 1'b1;
    end else if (p == utcep_pkg::POS_COLON_HOUR || p == utcep_pkg::POS_COLON_MIN) begin
      if (c != utcep_pkg::CHAR_COLON) err_upd = 1'b1;
    end else if (p == utcep_pkg::POS_ZULU) begin
      if (c != utcep_pkg::CHAR_ZULU) err_upd = 1'b1;
    end else if (!is_digit) begin
      err_upd = 1'b1;
    end else if (p < utcep_pkg::POS_DASH_YEAR) begin
      year_upd = utcep_pkg::YEAR_W'(18'(year_r) * 18'd10 + 18'(dv));
    end else if (p < utcep_pkg::POS_DASH_MONTH) begin
      month_upd = utcep_pkg::FIELD_W'(11'(month_r) * 11'd10 + 11'(dv));
    end else if (p < utcep_pkg::POS_TEE) begin
      day_upd = utcep_pkg::FIELD_W'(11'(day_r) * 11'd10 + 11'(dv));
    end else if (p < utcep_pkg::POS_COLON_HOUR) begin
      hour_upd = utcep_pkg::FIELD_W'(11'(hour_r) * 11'd10 + 11'(dv));
    end else if (p < utcep_pkg::POS_COLON_MIN) begin
      min_upd = utcep_pkg::FIELD_W'(11'(min_r) * 11'd10 + 11'(dv));
    end else begin
      sec_upd = utcep_pkg::FIELD_W'(11'(sec_r) * 11'd10 + 11'(dv));
    end
    pos_upd = (p < utcep_pkg::POS_MAX) ? p + 1'b1 : utcep_pkg::POS_MAX;
  end

  // The last character hands its fields to the queue and clears the parser.
  always_comb begin
    push_job.year    = year_upd;
    push_job.month   = month_upd;
    push_job.day     = day_upd;
    push_job.hour    = hour_upd;
    push_job.minute  = min_upd;
    push_job.second  = sec_upd;
    push_job.form_ok = !err_upd && (pos_upd == utcep_pkg::POS_LEN);
    push             = accept && in_ch.is_last;

    pos_nxt   = pos_r;
    err_nxt   = err_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    if (accept) begin
      if (in_ch.is_last) begin
        pos_nxt   = '0;
        err_nxt   = 1'b0;
        year_nxt  = '0;
        month_nxt = '0;
        day_nxt   = '0;
        hour_nxt  = '0;
        min_nxt   = '0;
        sec_nxt   = '0;
      end else begin
        pos_nxt   = pos_upd;
        err_nxt   = err_upd;
        year_nxt  = year_upd;
        month_nxt = month_upd;
        day_nxt   = day_upd;
        hour_nxt  = hour_upd;
        min_nxt   = min_upd;
        sec_nxt   = sec_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      err_r   <= 1'b0;
      year_r  <= '0;
      month_r <= '0;
      day_r   <= '0;
      hour_r  <= '0;
      min_r   <= '0;
      sec_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
    end
  end

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= utcep_pkg::POS_MAX)
    else $error("character count ran past saturation");

endmodule

>>> rtl/core/utcep_queue.sv
`timescale 1ns / 1ps

module utcep_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  utcep_pkg::job_t      push_job,
  input  logic                 pop,
  output utcep_pkg::job_t      pop_job,
  output utcep_pkg::q_status_t q_status
);

  utcep_pkg::job_t                   mem_r [utcep_pkg::QUEUE_DEPTH];
  logic [utcep_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [utcep_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [utcep_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                              do_push, do_pop;

  assign q_status.full  = (count_r == utcep_pkg::QCNT_W'(utcep_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_job        = mem_r[rd_ptr_r];

  function automatic logic [utcep_pkg::QPTR_W-1:0] ptr_inc(
      input logic [utcep_pkg::QPTR_W-1:0] ptr);
    logic [utcep_pkg::QPTR_W-1:0] r;
    if (ptr == utcep_pkg::QPTR_W'(utcep_pkg::QUEUE_DEPTH - 1)) r = '0;
    else r = ptr + 1'b1;
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= utcep_pkg::QCNT_W'(utcep_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("request pushed into a full queue");

endmodule

>>> rtl/core/utcep_back.sv
`timescale 1ns / 1ps

module utcep_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  utcep_pkg::q_status_t q_status,
  input  utcep_pkg::job_t      pop_job,
  output logic                 pop,
  utcep_out_if.source          out_ch
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RANGE = 3'd1;
  localparam logic [2:0] ST_SPLIT = 3'd2;
  localparam logic [2:0] ST_YEAR  = 3'd3;
  localparam logic [2:0] ST_DAYS  = 3'd4;
  localparam logic [2:0] ST_SECS  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_ok_r;
  logic signed [utcep_pkg::EPOCH_W-1:0] out_epoch_r;
  logic        load_out;

  utcep_pkg::job_t job_r;
  logic        ok_r;
  logic [14:0] yy_r;
  logic [6:0]  era_r;
  logic [8:0]  q100_r;
  logic [9:0]  doy_r;
  logic [16:0] tod_r;
  logic [8:0]  yoe_r;
  logic [21:0] era_days_r;
  logic [2:0]  yoe_q_r;
  logic [17:0] yoe365_r;
  logic signed [23:0] days_r;
  logic signed [utcep_pkg::EPOCH_W-1:0] secs_r;

  // Range step.
  logic        range_ok;
  logic        early_month;
  logic [14:0] yy;
  logic [21:0] era_prod;
  logic [23:0] q100_prod;
  logic [9:0]  doy;
  logic [16:0] tod;
  // Split step.
  logic [14:0] yoe_full;
  logic [13:0] r100;
  logic        leap;
  logic        day_ok;
  // Year step.
  logic [17:0] yoe_q_prod;

  assign early_month = job_r.month <= utcep_pkg::MONTH_FEB;
  assign range_ok = job_r.form_ok
      && job_r.hour <= utcep_pkg::HOUR_MAX
      && job_r.minute <= utcep_pkg::MINSEC_MAX
      && job_r.second <= utcep_pkg::MINSEC_MAX
      && job_r.year <= utcep_pkg::YEAR_MAX
      && job_r.month != '0 && job_r.month <= utcep_pkg::MONTH_DEC
      && job_r.day != '0;
  assign yy = 15'(job_r.year) + 15'(utcep_pkg::ERA_OFS) - 15'(early_month);
  // Division by 400 and 100 as a shift followed by a reciprocal multiply for 25.
  assign era_prod  = 22'(yy[14:4]) * 22'(utcep_pkg::RECIP25);
  assign q100_prod = 24'(job_r.year[13:2]) * 24'(utcep_pkg::RECIP25);
  assign doy = 10'(utcep_pkg::month_offset(job_r.month)) + 10'(job_r.day) - 10'd1;
  assign tod = 17'(job_r.hour) * 17'd3600 + 17'(job_r.minute) * 17'd60
      + 17'(job_r.second);

  assign yoe_full = yy_r - 15'(era_r) * 15'd400;
  assign r100     = job_r.year - 14'(q100_r) * 14'd100;
  // A century year is a leap year only when its century count is a multiple of four.
  assign leap = (job_r.year[1:0] == 2'b00 && r100 != '0)
      || (r100 == '0 && q100_r[1:0] == 2'b00);
  assign day_ok = job_r.day <= 7'(utcep_pkg::month_len(job_r.month, leap));

  assign yoe_q_prod = 18'(yoe_r[8:2]) * 18'(utcep_pkg::RECIP25);

  assign pop      = (state_r == ST_IDLE) && !q_status.empty;
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (!q_status.empty) state_nxt = ST_RANGE;
      ST_RANGE: state_nxt = ST_SPLIT;
      ST_SPLIT: state_nxt = ST_YEAR;
      ST_YEAR:  state_nxt = ST_DAYS;
      ST_DAYS:  state_nxt = ST_SECS;
      ST_SECS:  state_nxt = ST_OUT;
      ST_OUT:   if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= pop_job;
    if (state_r == ST_RANGE) begin
      ok_r   <= range_ok;
      yy_r   <= yy;
      era_r  <= era_prod[utcep_pkg::RECIP_SH +: 7];
      q100_r <= q100_prod[utcep_pkg::RECIP_SH +: 9];
      doy_r  <= doy;
      tod_r  <= tod;
    end
    if (state_r == ST_SPLIT) begin
      ok_r       <= ok_r && day_ok;
      yoe_r      <= yoe_full[8:0];
      era_days_r <= 22'(era_r) * 22'(utcep_pkg::DAYS_ERA);
    end
    if (state_r == ST_YEAR) begin
      yoe_q_r  <= yoe_q_prod[utcep_pkg::RECIP_SH +: 3];
      yoe365_r <= 18'(yoe_r) * 18'd365;
    end
    if (state_r == ST_DAYS) begin
      days_r <= $signed(24'(era_days_r) + 24'(yoe365_r) + 24'(yoe_r[8:2])
          - 24'(yoe_q_r) + 24'(doy_r) - 24'(utcep_pkg::EPOCH_OFS));
    end
    if (state_r == ST_SECS) begin
      secs_r <= utcep_pkg::EPOCH_W'(days_r) * $signed(utcep_pkg::EPOCH_W'(86400))
          + $signed(utcep_pkg::EPOCH_W'(tod_r));
    end
    if (load_out) begin
      out_ok_r    <= ok_r;
      out_epoch_r <= ok_r ? secs_r : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.valid_res     = out_ok_r;
  assign out_ch.epoch_seconds = out_epoch_r;

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> out_epoch_r == '0)
    else $error("rejected timestamp carries nonzero seconds");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == ST_IDLE && !q_status.empty)
    else $error("queue popped while a conversion is in flight");

endmodule
